### rtl/core/typed_bracket_structure_checker_macros.svh
// Assertion macros shared by the bracket checker RTL.
`ifndef TYPED_BRACKET_STRUCTURE_CHECKER_MACROS_SVH
`define TYPED_BRACKET_STRUCTURE_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define TBSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TBSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBSC_ASSERT(lbl, clk, rstn, prop, msg)
`define TBSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/tbsc_pkg.sv
// Types, constants and character decode for the bracket structure checker.
`timescale 1ns / 1ps
package tbsc_pkg;

    localparam int MAX_LEN = 4096;
    localparam int SP_W    = $clog2(MAX_LEN + 1);
    localparam int CNT_W   = $clog2(MAX_LEN + 2);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SEQ_W   = 16;
    localparam int CMP_W   = (CNT_W > SEQ_W) ? CNT_W : SEQ_W;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_OPEN_R  = 8'h28;
    localparam logic [7:0] CH_OPEN_C  = 8'h7B;
    localparam logic [7:0] CH_OPEN_S  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_R = 8'h29;
    localparam logic [7:0] CH_CLOSE_C = 8'h7D;
    localparam logic [7:0] CH_CLOSE_S = 8'h5D;

    typedef enum logic [1:0] {
        BT_ROUND  = 2'd0,
        BT_CURLY  = 2'd1,
        BT_SQUARE = 2'd2,
        BT_NONE   = 2'd3
    } bt_t;

    typedef enum logic [1:0] {
        BERR_NONE        = 2'd0,
        BERR_EXTRA_CLOSE = 2'd1,
        BERR_MISMATCH    = 2'd2
    } berr_t;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_TOO_LONG   = 3'd1,
        ERR_EMPTY      = 3'd2,
        ERR_LEN        = 3'd3,
        ERR_BAD_CHAR   = 3'd4,
        ERR_EXTRA      = 3'd5,
        ERR_MISMATCH   = 3'd6,
        ERR_UNCLOSED   = 3'd7
    } err_code_t;

    typedef struct packed {
        logic [7:0]       ch;
        logic [SEQ_W-1:0] seq_length;
    } in_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
    } out_t;

    typedef struct packed {
        logic done;
        out_t res;
    } verdict_t;

    function automatic bt_t open_type(input logic [7:0] c);
        case (c)
            CH_OPEN_R: open_type = BT_ROUND;
            CH_OPEN_C: open_type = BT_CURLY;
            CH_OPEN_S: open_type = BT_SQUARE;
            default:   open_type = BT_NONE;
        endcase
    endfunction

    function automatic bt_t close_type(input logic [7:0] c);
        case (c)
            CH_CLOSE_R: close_type = BT_ROUND;
            CH_CLOSE_C: close_type = BT_CURLY;
            CH_CLOSE_S: close_type = BT_SQUARE;
            default:    close_type = BT_NONE;
        endcase
    endfunction

endpackage

### rtl/core/typed_bracket_structure_checker.sv
// Top level of the typed bracket structure checker.
//
// Input channel chr: one structure character per beat (chr_data.ch), with
// chr_data.seq_length looked at only on the NUL beat that ends a string.
// Open brackets ( { [ are pushed as 2-bit types into a stack RAM; close
// brackets ) } ] must match the top entry, which is kept in a register.
// Output channel res: one beat per string, carrying valid_res and
// error_code, sent for the NUL beat only; other characters give no beat.
// Throughput: one character per cycle while chr is not stalled, set by the push/pop on
// the top-of-stack register and the RAM read port, which prefetches the
// entry under the top every cycle.
// The verdict is registered and appears on res in the cycle after the NUL beat is taken.
// A stall on res holds the verdict register; chr is stalled only while a
// verdict waits and res_stall is high, so beats flow when it is taken.
// Reset clears pointer, count and error flags; the stack RAM needs no
// clearing since only entries written in the current string are read.
`timescale 1ns / 1ps
`include "typed_bracket_structure_checker_macros.svh"
module typed_bracket_structure_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           chr_valid,
    output logic           chr_stall,
    input  tbsc_pkg::in_t  chr_data,
    output logic           res_valid,
    input  logic           res_stall,
    output tbsc_pkg::out_t res_data
);
    import tbsc_pkg::*;

    logic     acc;
    verdict_t verdict;
    logic     res_valid_reg, res_valid_next;
    out_t     res_data_reg;

    assign chr_stall = res_valid_reg && res_stall;
    assign acc       = chr_valid && !chr_stall;

    tbsc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .item    (chr_data),
        .verdict (verdict)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (verdict.done)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // load the verdict only on an end beat; otherwise hold
    always_ff @(posedge clk)
    begin
        if (verdict.done)
        begin
            res_data_reg <= verdict.res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `TBSC_ASSERT(a_end_gives_result, clk, rst_n, verdict.done |=> res_valid_reg, "verdict lost after end beat")
    `TBSC_ASSERT(a_no_accept_on_hold, clk, rst_n, (res_valid_reg && res_stall) |-> !acc, "beat taken while verdict held")

endmodule

### rtl/core/tbsc_stack_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module tbsc_stack_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tbsc_ctrl.sv
// Stack control, counters and verdict logic around the bracket stack RAM.
`timescale 1ns / 1ps
`include "typed_bracket_structure_checker_macros.svh"
module tbsc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            acc,
    input  tbsc_pkg::in_t   item,
    output tbsc_pkg::verdict_t verdict
);
    import tbsc_pkg::*;

    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             bad_reg, bad_next;
    berr_t            berr_reg, berr_next;
    bt_t              top_reg, top_next;

    bt_t              ot, ct;
    logic             is_end;
    logic             wr_en;
    logic [SP_W-1:0]  rd_ptr;
    logic [1:0]       below;
    err_code_t        code;

    // RAM holds every pushed entry; the read port always prefetches the entry
    // under the top, so a pop takes the new top straight from the read data.
    tbsc_stack_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (2)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sp_reg[ADDR_W-1:0]),
        .wr_data (ot),
        .rd_addr (rd_ptr[ADDR_W-1:0]),
        .rd_data (below)
    );

    assign rd_ptr = sp_next - SP_W'(2);

    always_comb
    begin
        ot        = open_type(item.ch);
        ct        = close_type(item.ch);
        is_end    = (item.ch == CH_NUL);
        sp_next   = sp_reg;
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        berr_next = berr_reg;
        top_next  = top_reg;
        wr_en     = 1'b0;
        if (acc)
        begin
            if (is_end)
            begin
                sp_next   = '0;
                cnt_next  = '0;
                bad_next  = 1'b0;
                berr_next = BERR_NONE;
            end
            else
            begin
                if (cnt_reg <= CNT_W'(MAX_LEN))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (ot == BT_NONE && ct == BT_NONE && item.ch != CH_DOT &&
                    item.ch != CH_UNDER)
                begin
                    bad_next = 1'b1;
                end
                // after the first bracket error the stack is frozen
                if (berr_reg == BERR_NONE)
                begin
                    if (ot != BT_NONE)
                    begin
                        if (sp_reg < SP_W'(MAX_LEN))
                        begin
                            wr_en    = 1'b1;
                            sp_next  = sp_reg + SP_W'(1);
                            top_next = ot;
                        end
                    end
                    else if (ct != BT_NONE)
                    begin
                        if (sp_reg == '0)
                        begin
                            berr_next = BERR_EXTRA_CLOSE;
                        end
                        else if (top_reg != ct)
                        begin
                            berr_next = BERR_MISMATCH;
                        end
                        else
                        begin
                            sp_next  = sp_reg - SP_W'(1);
                            top_next = bt_t'(below);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (cnt_reg > CNT_W'(MAX_LEN))
        begin
            code = ERR_TOO_LONG;
        end
        else if (cnt_reg == '0)
        begin
            code = ERR_EMPTY;
        end
        else if (CMP_W'(cnt_reg) != CMP_W'(item.seq_length))
        begin
            code = ERR_LEN;
        end
        else if (bad_reg)
        begin
            code = ERR_BAD_CHAR;
        end
        else if (berr_reg == BERR_EXTRA_CLOSE)
        begin
            code = ERR_EXTRA;
        end
        else if (berr_reg == BERR_MISMATCH)
        begin
            code = ERR_MISMATCH;
        end
        else if (sp_reg != '0)
        begin
            code = ERR_UNCLOSED;
        end
        else
        begin
            code = ERR_OK;
        end
        verdict.done           = acc && is_end;
        verdict.res.valid_res  = (code == ERR_OK);
        verdict.res.error_code = code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
            berr_reg <= BERR_NONE;
        end
        else
        begin
            sp_reg   <= sp_next;
            cnt_reg  <= cnt_next;
            bad_reg  <= bad_next;
            berr_reg <= berr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    `TBSC_ASSERT(a_sp_bound, clk, rst_n, (sp_reg <= SP_W'(MAX_LEN)),
                 "stack pointer beyond depth")
    `TBSC_ASSERT(a_cnt_bound, clk, rst_n, (cnt_reg <= CNT_W'(MAX_LEN + 1)),
                 "count past saturation")
    `TBSC_ASSERT(a_end_clears, clk, rst_n,
                 (acc && is_end) |=>
                 (sp_reg == '0 && cnt_reg == '0 && berr_reg == BERR_NONE),
                 "string state not cleared at end")
    `TBSC_ASSERT(a_frozen_stack, clk, rst_n,
                 (acc && !is_end && berr_reg != BERR_NONE) |=> $stable(sp_reg),
                 "stack moved after bracket error")

endmodule

### verif/bracket_verdict_checker.sv
// Scoreboard for the bracket structure checker: predicts verdicts and compares result beats.
`timescale 1ns / 1ps
module bracket_verdict_checker
    import tbsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic chr_valid,
    input  logic chr_stall,
    input  in_t  chr_data,
    input  logic res_valid,
    input  logic res_stall,
    input  out_t res_data,
    output int   mismatches,
    output int   verdicts_pending
);

    bt_t   open_stack [MAX_LEN];
    int    depth;
    int    chars_seen;
    bit    saw_illegal;
    berr_t first_err;
    out_t  expected_verdicts [$];

    function automatic void clear_string();
        depth       = 0;
        chars_seen  = 0;
        saw_illegal = 1'b0;
        first_err   = BERR_NONE;
    endfunction

    // Advance the string state by one beat; returns 1 when the beat ends a string.
    function automatic bit judge_char(input in_t beat, output out_t verdict);
        bt_t       ot;
        bt_t       ct;
        err_code_t code;
        verdict = '0;
        if (beat.ch != CH_NUL)
        begin
            if (chars_seen <= MAX_LEN)
            begin
                chars_seen++;
            end
            case (beat.ch)
                CH_OPEN_R: ot = BT_ROUND;
                CH_OPEN_C: ot = BT_CURLY;
                CH_OPEN_S: ot = BT_SQUARE;
                default:   ot = BT_NONE;
            endcase
            case (beat.ch)
                CH_CLOSE_R: ct = BT_ROUND;
                CH_CLOSE_C: ct = BT_CURLY;
                CH_CLOSE_S: ct = BT_SQUARE;
                default:    ct = BT_NONE;
            endcase
            if (ot == BT_NONE && ct == BT_NONE && beat.ch != CH_DOT && beat.ch != CH_UNDER)
            begin
                saw_illegal = 1'b1;
            end
            // Once a bracket error is latched the stack is frozen until the end beat.
            if (first_err == BERR_NONE)
            begin
                if (ot != BT_NONE)
                begin
                    if (depth < MAX_LEN)
                    begin
                        open_stack[depth] = ot;
                        depth++;
                    end
                end
                else if (ct != BT_NONE)
                begin
                    if (depth == 0)
                    begin
                        first_err = BERR_EXTRA_CLOSE;
                    end
                    else if (open_stack[depth-1] != ct)
                    begin
                        first_err = BERR_MISMATCH;
                    end
                    else
                    begin
                        depth--;
                    end
                end
            end
            return 1'b0;
        end

        if (chars_seen > MAX_LEN)
            code = ERR_TOO_LONG;
        else if (chars_seen == 0)
            code = ERR_EMPTY;
        else if (chars_seen != int'(beat.seq_length))
            code = ERR_LEN;
        else if (saw_illegal)
            code = ERR_BAD_CHAR;
        else if (first_err == BERR_EXTRA_CLOSE)
            code = ERR_EXTRA;
        else if (first_err == BERR_MISMATCH)
            code = ERR_MISMATCH;
        else if (depth != 0)
            code = ERR_UNCLOSED;
        else
            code = ERR_OK;
        verdict.valid_res  = (code == ERR_OK);
        verdict.error_code = code;
        clear_string();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        out_t predicted;
        if (!rst_n)
        begin
            clear_string();
            expected_verdicts.delete();
            mismatches = 0;
        end
        else
        begin
            // Check the result beat first: a verdict for this edge's end beat comes later.
            if (res_valid && !res_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected verdict beat: valid_res %0d error_code %0d",
                           res_data.valid_res, res_data.error_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (res_data.valid_res !== want.valid_res)
                    begin
                        $error("valid_res: expected %0d actual %0d",
                               want.valid_res, res_data.valid_res);
                        mismatches++;
                    end
                    if (res_data.error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d actual %0d",
                               want.error_code, res_data.error_code);
                        mismatches++;
                    end
                end
            end
            if (chr_valid && !chr_stall)
            begin
                if (judge_char(chr_data, predicted))
                begin
                    expected_verdicts.push_back(predicted);
                end
            end
        end
        verdicts_pending = expected_verdicts.size();
    end

endmodule

### verif/testbench.sv
// Top of the bracket structure checker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import tbsc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam logic [7:0] LEGAL_CHARS [8] = '{CH_DOT, CH_UNDER, CH_OPEN_R, CH_OPEN_C,
                                               CH_OPEN_S, CH_CLOSE_R, CH_CLOSE_C, CH_CLOSE_S};

    logic clk;
    logic rst_n;
    logic chr_valid;
    logic chr_stall;
    in_t  chr_data;
    logic res_valid;
    logic res_stall;
    out_t res_data;

    int         fail_count;
    int         verdicts_pending;
    int         idle_cycles;
    int         random_sent;
    bit         no_gaps;
    logic [7:0] chars [$];

    typed_bracket_structure_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_data  (chr_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    bracket_verdict_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .chr_valid        (chr_valid),
        .chr_stall        (chr_stall),
        .chr_data         (chr_data),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .res_data         (res_data),
        .mismatches       (fail_count),
        .verdicts_pending (verdicts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 30);
    endfunction

    function automatic logic [7:0] open_char(input bt_t t);
        case (t)
            BT_ROUND: return CH_OPEN_R;
            BT_CURLY: return CH_OPEN_C;
            default:  return CH_OPEN_S;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input bt_t t);
        case (t)
            BT_ROUND: return CH_CLOSE_R;
            BT_CURLY: return CH_CLOSE_C;
            default:  return CH_CLOSE_S;
        endcase
    endfunction

    // Hold the beat until it is taken; stall is sampled on the falling edge.
    task automatic send_beat(input logic [7:0] ch, input logic [15:0] slen);
        int gap;
        bit taken;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            chr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chr_valid <= 1'b1;
        chr_data  <= '{ch: ch, seq_length: slen};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !chr_stall;
            @(posedge clk);
        end
    endtask

    task automatic send_text(input logic [15:0] slen);
        foreach (chars[i])
        begin
            send_beat(chars[i], 16'($urandom));
        end
        send_beat(CH_NUL, slen);
        chars.delete();
    endtask

    task automatic load(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            chars.push_back(s[i]);
        end
    endtask

    task automatic drain();
        chr_valid <= 1'b0;
        @(negedge clk);
        wait (verdicts_pending == 0);
        @(posedge clk);
    endtask

    task automatic build_nested(input int pairs);
        bt_t open_types [$];
        bt_t t;
        int  opens_left;
        int  r;
        opens_left = pairs;
        while (opens_left > 0 || open_types.size() > 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                chars.push_back(r == 0 ? CH_DOT : CH_UNDER);
            end
            else if (opens_left > 0 && (open_types.size() == 0 || r < 6))
            begin
                t = bt_t'($urandom_range(0, 2));
                open_types.push_back(t);
                chars.push_back(open_char(t));
                opens_left--;
            end
            else
            begin
                chars.push_back(close_char(open_types.pop_back()));
            end
        end
    endtask

    task automatic random_text();
        int         kind;
        int         idx;
        int         closes [$];
        logic [7:0] c;
        logic [15:0] slen;
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            build_nested(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
        end
        foreach (chars[i])
        begin
            if (chars[i] inside {CH_CLOSE_R, CH_CLOSE_C, CH_CLOSE_S})
                closes.push_back(i);
        end
        if (kind >= 55 && kind < 65)
        begin
            // swap the type of one close bracket
            idx = closes[$urandom_range(0, closes.size() - 1)];
            c = chars[idx];
            chars[idx] = (c == CH_CLOSE_R) ? CH_CLOSE_C :
                         (c == CH_CLOSE_C) ? CH_CLOSE_S : CH_CLOSE_R;
        end
        else if (kind >= 65 && kind < 72)
        begin
            chars.insert($urandom_range(0, chars.size()),
                         close_char(bt_t'($urandom_range(0, 2))));
        end
        else if (kind >= 72 && kind < 79)
        begin
            chars.delete(closes[$urandom_range(0, closes.size() - 1)]);
        end
        else if (kind >= 79 && kind < 85)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c inside {LEGAL_CHARS});
            chars.insert($urandom_range(0, chars.size()), c);
        end
        else if (kind >= 85 && kind < 95)
        begin
            repeat ($urandom_range(1, 30))
            begin
                if ($urandom_range(0, 1))
                    chars.push_back(LEGAL_CHARS[$urandom_range(0, 7)]);
                else
                    chars.push_back(8'($urandom_range(1, 255)));
            end
        end
        slen = 16'(chars.size());
        if ((kind >= 45 && kind < 55) || kind >= 95)
        begin
            slen = $urandom_range(0, 1) ? 16'($urandom) : 16'(chars.size() + 1);
        end
        random_sent += chars.size() + 1;
        send_text(slen);
    endtask

    initial
    begin
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int r;
            int hold;
            int run;
            r = $urandom_range(0, 99);
            hold = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 3) :
                   (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 40);
            r = $urandom_range(0, 99);
            run = (r < 60) ? $urandom_range(1, 4) :
                  (r < 90) ? $urandom_range(5, 20) : $urandom_range(50, 200);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            repeat (run) @(posedge clk);
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((chr_valid && !chr_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        chr_valid   = 1'b0;
        chr_data    = '0;
        no_gaps     = 1'b0;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text(16'd0);
        send_text(16'hFFFF);
        load("(.{_}[])");
        send_text(16'd8);
        load(")");
        send_text(16'd1);
        load("(]");
        send_text(16'd2);
        load("[");
        send_text(16'd1);
        load("()");
        send_text(16'd3);
        // illegal character outranks the extra close
        chars.push_back(8'hFF);
        chars.push_back(CH_CLOSE_R);
        send_text(16'd2);
        // bracket after an extra close must not reach the stack
        load(")(");
        send_text(16'd2);
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            random_text();
            if ($urandom_range(0, 11) == 0)
                drain();
        end

        chr_valid <= 1'b0;
        @(negedge clk);
        wait (verdicts_pending == 0);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
